@@ rtl/assert_macros.svh @@
// Assertion macros for the sorted key table RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside reset.
`define SKT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check a property on every clock edge, reset included.
`define SKT_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

@@ rtl/skt_pkg.sv @@
// Types and codes shared by the sorted key table modules.
package skt_pkg;

  localparam int KEY_W    = 32;
  localparam int FUNC_W   = 2;
  localparam int STATUS_W = 2;
  localparam int OCC_W    = 5;
  localparam int NAME_W   = 64;

  // Operation codes
  localparam logic [FUNC_W-1:0] FUNC_INSERT = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_FIND   = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_DELETE = 2'd2;

  // Result status codes
  localparam logic [STATUS_W-1:0] ST_DONE   = 2'd0;
  localparam logic [STATUS_W-1:0] ST_DUP    = 2'd1;
  localparam logic [STATUS_W-1:0] ST_ABSENT = 2'd2;
  localparam logic [STATUS_W-1:0] ST_FULL   = 2'd3;

  typedef logic signed [KEY_W-1:0] key_t;

  // Command broadcast to every cell of the chain
  typedef struct packed {
    logic ins;
    logic del;
    key_t key;
  } cmd_t;

endpackage

@@ rtl/skt_cell.sv @@
// One cell of the sorted chain: holds a key and payload and shifts with its neighbors.
module skt_cell #(
  parameter int NAME_BITS = 64
) (
  input  logic                 clk,
  input  logic                 valid,
  input  skt_pkg::cmd_t        cmd,
  input  logic [NAME_BITS-1:0] name_in,
  input  logic                 left_lt,
  input  skt_pkg::key_t        left_key,
  input  logic [NAME_BITS-1:0] left_name,
  input  skt_pkg::key_t        right_key,
  input  logic [NAME_BITS-1:0] right_name,
  output logic                 lt,
  output logic                 match,
  output skt_pkg::key_t        key_q,
  output logic [NAME_BITS-1:0] name_q
);
  import skt_pkg::*;

  key_t                 key_r;
  logic [NAME_BITS-1:0] name_r;

  // Compare the held key against the broadcast key
  assign lt     = valid && (key_r < cmd.key);
  assign match  = valid && (key_r == cmd.key);
  assign key_q  = key_r;
  assign name_q = name_r;

  // Insert: smaller keys hold, the first larger slot takes the new word,
  // the rest shift up. Delete: cells at or above the key pull from the right.
  always_ff @(posedge clk) begin
    if (cmd.ins && !lt) begin
      if (left_lt) begin
        key_r  <= cmd.key;
        name_r <= name_in;
      end else begin
        key_r  <= left_key;
        name_r <= left_name;
      end
    end else if (cmd.del && !lt) begin
      key_r  <= right_key;
      name_r <= right_name;
    end
  end

endmodule

@@ rtl/sorted_key_table.sv @@
// Top level of the sorted key table: cell chain, fill count and result register.
//
//  channel | ports            | direction | contents
//  --------+------------------+-----------+-----------------------------------
//  in      | in_tvalid/tready | slave     | tuser: func, tdata: key, name_in
//  out     | out_tvalid/tready| master    | tuser: status, tdata: name_out, occ
//
// One word per cycle while the output register is not stalled: each cell compares
// and shifts in the cycle of acceptance, and the result appears in the output register in the next cycle.
// Reset (rst_n low, synchronous) empties the table; stored keys and payloads
// are not cleared and are never read above the fill count.
// A stalled result blocks input only when the output register is full and
// not being taken in the same cycle.
module sorted_key_table #(
  parameter int DEPTH     = 16,
  parameter int NAME_BITS = 64
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_tvalid,
  output logic                         in_tready,
  input  logic [skt_pkg::FUNC_W-1:0]   in_tuser,  // [1:0] func
  input  logic [95:0]                  in_tdata,  // [31:0] key, [95:32] name_in
  output logic                         out_tvalid,
  input  logic                         out_tready,
  output logic [skt_pkg::STATUS_W-1:0] out_tuser, // [1:0] status
  output logic [71:0]                  out_tdata  // [63:0] name_out, [68:64] occupancy
);
  import skt_pkg::*;

  `include "assert_macros.svh"

  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [CNT_W-1:0]     count_r, count_nxt;
  logic                 out_valid_r;
  logic [STATUS_W-1:0]  status_r, status_nxt;
  logic [NAME_W-1:0]    name_out_r, name_out_nxt;
  logic [OCC_W-1:0]     occ_r;

  logic                 in_acc;
  logic [FUNC_W-1:0]    func;
  key_t                 key;
  logic [NAME_BITS-1:0] name_in;
  logic                 hit, full, ins_ok, del_ok;
  cmd_t                 cmd;

  logic [DEPTH-1:0]     valid, lt, match;
  key_t                 key_q  [DEPTH];
  logic [NAME_BITS-1:0] name_q [DEPTH];
  logic [NAME_BITS-1:0] found;

  // Unpack the input word
  assign func    = in_tuser;
  assign key     = key_t'(in_tdata[31:0]);
  assign name_in = in_tdata[32 +: NAME_BITS];

  assign in_tready = !out_valid_r || out_tready;
  assign in_acc    = in_tvalid && in_tready;

  assign hit    = |match;
  assign full   = (count_r == CNT_W'(DEPTH));
  assign ins_ok = in_acc && (func == FUNC_INSERT) && !hit && !full;
  assign del_ok = in_acc && (func == FUNC_DELETE) && hit;

  assign cmd.ins = ins_ok;
  assign cmd.del = del_ok;
  assign cmd.key = key;

  // Build the chain of cells
  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic                 l_lt;
    key_t                 l_key, r_key;
    logic [NAME_BITS-1:0] l_name, r_name;

    assign valid[g] = (count_r > CNT_W'(g));

    if (g == 0) begin : g_first
      assign l_lt   = 1'b1;
      assign l_key  = key_q[g];
      assign l_name = name_q[g];
    end else begin : g_mid
      assign l_lt   = lt[g-1];
      assign l_key  = key_q[g-1];
      assign l_name = name_q[g-1];
    end

    if (g == DEPTH - 1) begin : g_last
      assign r_key  = key_q[g];
      assign r_name = name_q[g];
    end else begin : g_inner
      assign r_key  = key_q[g+1];
      assign r_name = name_q[g+1];
    end

    skt_cell #(.NAME_BITS(NAME_BITS)) u_cell (
      .clk        (clk),
      .valid      (valid[g]),
      .cmd        (cmd),
      .name_in    (name_in),
      .left_lt    (l_lt),
      .left_key   (l_key),
      .left_name  (l_name),
      .right_key  (r_key),
      .right_name (r_name),
      .lt         (lt[g]),
      .match      (match[g]),
      .key_q      (key_q[g]),
      .name_q     (name_q[g])
    );
  end

  // Gather the payload of the matching cell (at most one matches)
  always_comb begin
    found = '0;
    for (int i = 0; i < DEPTH; i++) begin
      if (match[i]) found = found | name_q[i];
    end
  end

  // Form the status and the next fill count
  always_comb begin
    status_nxt   = ST_DONE;
    name_out_nxt = '0;
    count_nxt    = count_r;
    unique case (func)
      FUNC_INSERT: begin
        if (hit)       status_nxt = ST_DUP;
        else if (full) status_nxt = ST_FULL;
        else           count_nxt  = count_r + CNT_W'(1);
      end
      FUNC_FIND: begin
        if (hit) name_out_nxt = NAME_W'(found);
        else     status_nxt   = ST_ABSENT;
      end
      FUNC_DELETE: begin
        if (hit) count_nxt  = count_r - CNT_W'(1);
        else     status_nxt = ST_ABSENT;
      end
      default: begin
        status_nxt = ST_DONE;
      end
    endcase
  end

  // Hold the fill count and output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_acc) count_r <= count_nxt;
      if (in_acc) out_valid_r <= 1'b1;
      else if (out_tready) out_valid_r <= 1'b0;
    end
  end

  // Capture the result word
  always_ff @(posedge clk) begin
    if (in_acc) begin
      status_r   <= status_nxt;
      name_out_r <= name_out_nxt;
      occ_r      <= OCC_W'(count_nxt);
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = status_r;
  assign out_tdata  = {3'b000, occ_r, name_out_r};

  `SKT_ASSERT(a_count_bound, count_r <= CNT_W'(DEPTH), "fill count exceeds depth")
  `SKT_ASSERT(a_one_match, $onehot0(match), "more than one cell matches the key")
  `SKT_ASSERT(a_ins_grow, ins_ok |=> count_r == $past(count_r) + CNT_W'(1),
              "insert did not grow the table")
  `SKT_ASSERT(a_result_due, in_acc |=> out_valid_r, "accepted word produced no result")
  `SKT_ASSERT_ALWAYS(a_reset_empty, !rst_n |=> (count_r == '0 && !out_valid_r),
                     "reset did not empty the table")

endmodule

@@ tb/tb_sorted_key_table.sv @@
`timescale 1ns / 1ps
// Testbench for the sorted key table: random and directed operations against a mirror table.
module tb_sorted_key_table;
  import skt_pkg::*;

  localparam int DEPTH        = 16;
  localparam int CLK_HALF     = 4;
  localparam int RESET_CYCLES = 12;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int MAX_SHOWN    = 10;
  localparam int KEY_POOL     = 24;
  localparam int GAP_PCT      = 9;

  // Unused operation code: the block answers it without touching the table
  localparam logic [FUNC_W-1:0] FUNC_NOP = 2'd3;

  localparam key_t KEY_MIN = 32'sh8000_0000;
  localparam key_t KEY_MAX = 32'sh7fff_ffff;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [NAME_W-1:0]   name;
    logic [OCC_W-1:0]    occ;
  } result_t;

  logic                clk        = 1'b0;
  logic                rst_n      = 1'b0;
  logic                in_tvalid  = 1'b0;
  logic                in_tready;
  logic [FUNC_W-1:0]   in_tuser   = '0;  // [1:0] func
  logic [95:0]         in_tdata   = '0;  // [31:0] key, [95:32] name_in
  logic                out_tvalid;
  logic                out_tready = 1'b0;
  logic [STATUS_W-1:0] out_tuser;        // [1:0] status
  logic [71:0]         out_tdata;        // [63:0] name_out, [68:64] occupancy

  // Mirror of the table contents, kept in ascending key order
  key_t              held_keys  [DEPTH];
  logic [NAME_W-1:0] held_names [DEPTH];
  int                held_count  = 0;

  result_t pending_results [$];
  key_t    key_pool [KEY_POOL];
  int      fail_count  = 0;
  int      cycle_count = 0;
  bit      no_gaps     = 1'b0;

  sorted_key_table #(
    .DEPTH    (DEPTH),
    .NAME_BITS(NAME_W)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tuser  (in_tuser),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tuser (out_tuser),
    .out_tdata (out_tdata)
  );

  always #CLK_HALF clk = ~clk;

  // Apply one operation to the mirror table and return the word it should produce
  function automatic result_t predict_table_op(input logic [FUNC_W-1:0] op, input key_t k,
                                               input logic [NAME_W-1:0] nm);
    result_t r;
    int      hit;
    int      pos;
    r        = '0;
    r.status = ST_DONE;
    hit      = -1;
    for (int i = 0; i < held_count; i++)
      if (held_keys[i] == k) hit = i;
    case (op)
      FUNC_INSERT: begin
        // duplicate check comes before the full check
        if (hit >= 0) begin
          r.status = ST_DUP;
        end else if (held_count >= DEPTH) begin
          r.status = ST_FULL;
        end else begin
          pos = 0;
          while (pos < held_count && held_keys[pos] < k) pos++;
          for (int i = held_count; i > pos; i--) begin
            held_keys[i]  = held_keys[i-1];
            held_names[i] = held_names[i-1];
          end
          held_keys[pos]  = k;
          held_names[pos] = nm;
          held_count++;
        end
      end
      FUNC_FIND: begin
        if (hit < 0) r.status = ST_ABSENT;
        else r.name = held_names[hit];
      end
      FUNC_DELETE: begin
        if (hit < 0) begin
          r.status = ST_ABSENT;
        end else begin
          // close the gap left by the removed entry
          for (int i = hit; i + 1 < held_count; i++) begin
            held_keys[i]  = held_keys[i+1];
            held_names[i] = held_names[i+1];
          end
          held_count--;
        end
      end
      default: ;
    endcase
    r.occ = held_count[OCC_W-1:0];
    return r;
  endfunction

  // Randomly hold off the result channel, except during a no-gap stretch
  always @(posedge clk) begin
    out_tready <= no_gaps || ($urandom_range(99) >= GAP_PCT);
  end

  // Predict each accepted word, then check each result word against the oldest prediction
  always @(posedge clk) begin : monitor
    result_t seen;
    result_t want;
    if (rst_n && in_tvalid && in_tready)
      pending_results.push_back(predict_table_op(in_tuser, in_tdata[31:0], in_tdata[95:32]));
    if (rst_n && out_tvalid && out_tready) begin
      seen = {out_tuser, out_tdata[63:0], out_tdata[68:64]};
      if (pending_results.size() == 0) begin
        fail_count++;
        if (fail_count <= MAX_SHOWN)
          $display("unexpected result word: status %0d name %h occupancy %0d",
                   seen.status, seen.name, seen.occ);
      end else begin
        want = pending_results.pop_front();
        if (seen.status !== want.status || seen.name !== want.name || seen.occ !== want.occ)
        begin
          fail_count++;
          if (fail_count <= MAX_SHOWN)
            $display("mismatch: want status %0d name %h occ %0d, got status %0d name %h occ %0d",
                     want.status, want.name, want.occ, seen.status, seen.name, seen.occ);
        end
      end
    end
  end

  // Stop a hung run
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // Offer one word and hold it until the block takes it
  task automatic send_op(input logic [FUNC_W-1:0] op, input key_t k,
                         input logic [NAME_W-1:0] nm);
    while (!no_gaps && $urandom_range(99) < GAP_PCT) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {nm, k};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  function automatic key_t pick_key();
    if ($urandom_range(99) < 80) return key_pool[$urandom_range(KEY_POOL-1)];
    return key_t'($urandom);
  endfunction

  function automatic logic [NAME_W-1:0] pick_name();
    int sel;
    sel = $urandom_range(9);
    if (sel == 0) return '0;
    if (sel == 1) return '1;
    return {$urandom, $urandom};
  endfunction

  // Extreme keys around zero and the ends of the range, plus adjacent random pairs
  task automatic fill_key_pool();
    key_pool[0] = KEY_MIN;
    key_pool[1] = KEY_MAX;
    key_pool[2] = '0;
    key_pool[3] = -1;
    key_pool[4] = 1;
    for (int i = 5; i < KEY_POOL; i++)
      key_pool[i] = (i % 2 == 1) ? key_t'($urandom) : key_pool[i-1] + 1;
  endtask

  // Empty-table misses, then inserts and finds at the key extremes
  task automatic test_extreme_keys();
    send_op(FUNC_FIND,   '0, '0);
    send_op(FUNC_DELETE, 5, '1);
    send_op(FUNC_INSERT, KEY_MAX, '1);
    send_op(FUNC_INSERT, KEY_MIN, '0);
    send_op(FUNC_INSERT, '0, 64'h0123_4567_89ab_cdef);
    send_op(FUNC_INSERT, -1, 64'haaaa_aaaa_aaaa_aaaa);
    send_op(FUNC_FIND,   KEY_MIN, '1);
    send_op(FUNC_FIND,   KEY_MAX, '0);
    send_op(FUNC_FIND,   '0, '0);
    send_op(FUNC_FIND,   -1, '0);
    send_op(FUNC_FIND,   1, '0);
  endtask

  // Duplicate insert, missing keys, the unused code, and emptying the table
  task automatic test_refusals();
    send_op(FUNC_INSERT, KEY_MAX, 64'h5555_5555_5555_5555);
    send_op(FUNC_FIND,   KEY_MAX, '0);
    send_op(FUNC_DELETE, '0, '0);
    send_op(FUNC_FIND,   '0, '0);
    send_op(FUNC_DELETE, '0, '0);
    send_op(FUNC_NOP,    -1, '1);
    send_op(FUNC_DELETE, KEY_MIN, '0);
    send_op(FUNC_DELETE, KEY_MAX, '0);
    send_op(FUNC_DELETE, -1, '0);
  endtask

  // Fill to capacity in scattered order, hit the full and duplicate cases, then drain
  task automatic test_fill_and_drain();
    key_t base;
    key_t fill_keys [DEPTH+1];
    base = key_t'($urandom);
    for (int i = 0; i <= DEPTH; i++) fill_keys[i] = base + key_t'(i * 7919);
    for (int i = 0; i <= DEPTH; i++)
      send_op(FUNC_INSERT, fill_keys[(i * 5) % (DEPTH + 1)], pick_name());
    send_op(FUNC_INSERT, fill_keys[0], pick_name());
    for (int i = 0; i <= DEPTH; i++) send_op(FUNC_FIND, fill_keys[i], pick_name());
    for (int i = 0; i <= DEPTH; i++)
      send_op(FUNC_DELETE, fill_keys[(i * 3) % (DEPTH + 1)], pick_name());
  endtask

  // Send a run of random operations with the given mix; the remainder is the unused code
  task automatic run_mix(input int count, input int ins_pct, input int find_pct,
                         input int del_pct);
    int                roll;
    logic [FUNC_W-1:0] op;
    for (int n = 0; n < count; n++) begin
      roll = $urandom_range(99);
      if (roll < ins_pct) op = FUNC_INSERT;
      else if (roll < ins_pct + find_pct) op = FUNC_FIND;
      else if (roll < ins_pct + find_pct + del_pct) op = FUNC_DELETE;
      else op = FUNC_NOP;
      send_op(op, pick_key(), pick_name());
    end
  endtask

  // Random traffic swinging the table between full and empty
  task automatic test_random_traffic();
    fill_key_pool();
    run_mix(85, 70, 20, 7);
    run_mix(85, 35, 35, 27);
    run_mix(85, 15, 30, 52);
    no_gaps = 1'b1;
    run_mix(90, 40, 30, 27);
    no_gaps = 1'b0;
    fill_key_pool();
    run_mix(80, 75, 15, 8);
    run_mix(80, 10, 25, 62);
  endtask

  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    test_extreme_keys();
    test_refusals();
    test_fill_and_drain();
    test_random_traffic();
    in_tvalid <= 1'b0;
    // wait out the remaining results, then a few more cycles for strays
    while (pending_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
